/* hdl/bgi_pkg.sv */
// ----------------------------------------------------------------------------
// bgi_pkg
// Shared types and constants for the uniform-grid bilinear interpolator.
// ----------------------------------------------------------------------------
package bgi_pkg;

  localparam int DATA_W    = 32;  // Q16.16 coordinate / value word
  localparam int PTS_W     = 7;   // point count register width
  localparam int CFG_IDX_W = 3;   // configuration register index width

  localparam logic [PTS_W-1:0] MIN_POINTS = PTS_W'(2);

  // request kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // result status
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_OOR = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_INV_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_INV_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_POINTS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_POINTS   = 3'd5;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_WAITY,
    S_INDEX,
    S_WRITE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_DONE
  } bgi_state_t;

endpackage

/* hdl/bgi_in_if.sv */
// ----------------------------------------------------------------------------
// bgi_in_if
// Request channel: add or evaluate at a Q16.16 position.
// ----------------------------------------------------------------------------
interface bgi_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic signed [31:0] z_value;

  modport source (output valid, kind, x_coord, y_coord, z_value, input ready);
  modport sink   (input valid, kind, x_coord, y_coord, z_value, output ready);
endinterface

/* hdl/bgi_out_if.sv */
// ----------------------------------------------------------------------------
// bgi_out_if
// Result channel: interpolated value and range status.
// ----------------------------------------------------------------------------
interface bgi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

/* hdl/bgi_mul.sv */
// ----------------------------------------------------------------------------
// bgi_mul
// Shared 33x33 signed multiplier with registered product.
// ----------------------------------------------------------------------------
module bgi_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* hdl/bgi_node_mem.sv */
// ----------------------------------------------------------------------------
// bgi_node_mem
// Single-port node table with registered read and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module bgi_node_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata,
  output logic          busy
);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      busy_r    <= busy_nxt;
    end
  end

  assign wr_en   = busy_r | we;
  assign wr_addr = busy_r ? clr_cnt_r : addr;
  assign wr_data = busy_r ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[addr];
  end

  assign busy = busy_r;

endmodule

/* hdl/bgi_axis.sv */
// ----------------------------------------------------------------------------
// bgi_axis
// Per-axis index decode: nearest node for adds, cell and fraction for
// evaluates, with the range checks for both.
// ----------------------------------------------------------------------------
module bgi_axis #(
  parameter int FRAC_BITS = 16,
  parameter int IW        = 6,
  parameter int NW        = 7
) (
  input  logic [63:0]        pos,      // |grid position|, Q(2*FRAC_BITS)
  input  logic               neg,
  input  logic [NW-1:0]      npts,     // effective node count
  output logic               add_ok,
  output logic [IW-1:0]      add_idx,
  output logic               ev_ok,
  output logic [IW-1:0]      ev_lo,
  output logic [FRAC_BITS:0] ev_f
);

  localparam int IPW = 64 - 2 * FRAC_BITS;
  localparam logic [63:0] HALF = 64'd1 << (2 * FRAC_BITS - 1);

  logic [IPW-1:0]         ip;
  logic [2*FRAC_BITS-1:0] fr;
  logic [IPW:0]           near;
  logic [NW-1:0]          nm1;
  logic [NW-1:0]          nm2;
  logic                   top;

  assign ip   = pos[63:2*FRAC_BITS];
  assign fr   = pos[2*FRAC_BITS-1:0];
  assign near = {1'b0, ip} + (IPW+1)'(pos[2*FRAC_BITS-1]);
  assign nm1  = npts - NW'(1);
  assign nm2  = npts - NW'(2);
  assign top  = (ip == IPW'(nm1));

  // nearest node, half rounds up; small negatives snap to node 0
  assign add_ok  = neg ? (pos <= HALF) : (near < (IPW+1)'(npts));
  assign add_idx = neg ? '0 : IW'(near);

  // the last node uses the last cell at full weight
  assign ev_ok = !neg && ((ip < IPW'(nm1)) || (top && (fr == '0)));
  assign ev_lo = top ? IW'(nm2) : IW'(ip);
  assign ev_f  = top ? (FRAC_BITS+1)'(1) << FRAC_BITS
                     : {1'b0, fr[2*FRAC_BITS-1:FRAC_BITS]};

endmodule

/* hdl/uniform_grid_bilinear_interp_unit.sv */
// ----------------------------------------------------------------------------
// uniform_grid_bilinear_interp_unit
// Bilinear interpolation over a uniform 2D table of Q16.16 node values.
// ----------------------------------------------------------------------------
// Holds a MAX_X_NODES x MAX_Y_NODES table of signed Q16.16 node values on a
// uniform grid set up through the cfg_ port (origin, reciprocal spacing and
// node counts per axis, counts clamped to 2..MAX). An add request rounds its
// position to the nearest node and stores z_value there; an evaluate request
// blends the four corners of the enclosing cell, along x and then along y,
// each blend rounded half up. Off-grid requests return zero with status 1.
// After reset the table is swept to zero one word per cycle; no request is
// taken until the sweep is done. One request is in flight at a time: the
// position products and index decode come first, then an add writes its
// node, an in-grid evaluate reads the four corners and runs the blend
// products, and an off-grid request goes straight to the result. The result
// enters the output register once it is free, and the sequencer returns to
// idle before the next request is taken. The spacing of requests comes from
// the single 33x33 multiplier shared by both position products and the six
// blend products, and from the single memory port that fetches the four
// corner nodes one by one. A new request is taken while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module uniform_grid_bilinear_interp_unit #(
  parameter int MAX_X_NODES = 64,
  parameter int MAX_Y_NODES = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  bgi_in_if.sink                           in_ch,
  bgi_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [bgi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgi_pkg::DATA_W-1:0]       cfg_wdata
);

  localparam int DEPTH = MAX_X_NODES * MAX_Y_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int XIW   = $clog2(MAX_X_NODES);
  localparam int YIW   = $clog2(MAX_Y_NODES);
  localparam int XNW   = $clog2(MAX_X_NODES + 1);
  localparam int YNW   = $clog2(MAX_Y_NODES + 1);
  localparam int PW    = bgi_pkg::PTS_W;

  localparam logic [AW-1:0]           ROW_STRIDE = AW'(MAX_Y_NODES);
  localparam logic [FRAC_BITS:0]      ONE_F      = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic signed [65:0]      RND_C      = 66'sd1 <<< (FRAC_BITS - 1);

  // ---------------------------------------------------------------- config
  logic signed [31:0] x_origin_r, y_origin_r;
  logic [31:0]        x_inv_r, y_inv_r;
  logic [PW-1:0]      x_pts_r, y_pts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= '0;
      y_origin_r <= '0;
      x_inv_r    <= 32'd65536;
      y_inv_r    <= 32'd65536;
      x_pts_r    <= bgi_pkg::MIN_POINTS;
      y_pts_r    <= bgi_pkg::MIN_POINTS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgi_pkg::CFG_X_ORIGIN:   x_origin_r <= cfg_wdata;
        bgi_pkg::CFG_Y_ORIGIN:   y_origin_r <= cfg_wdata;
        bgi_pkg::CFG_X_INV_STEP: x_inv_r    <= cfg_wdata;
        bgi_pkg::CFG_Y_INV_STEP: y_inv_r    <= cfg_wdata;
        bgi_pkg::CFG_X_POINTS:   x_pts_r    <= cfg_wdata[PW-1:0];
        bgi_pkg::CFG_Y_POINTS:   y_pts_r    <= cfg_wdata[PW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // effective node counts, clamped to 2..MAX
  logic [XNW-1:0] nx_eff;
  logic [YNW-1:0] ny_eff;

  assign nx_eff = (x_pts_r < bgi_pkg::MIN_POINTS) ? XNW'(2) :
                  (32'(x_pts_r) > 32'(MAX_X_NODES)) ? XNW'(MAX_X_NODES) : XNW'(x_pts_r);
  assign ny_eff = (y_pts_r < bgi_pkg::MIN_POINTS) ? YNW'(2) :
                  (32'(y_pts_r) > 32'(MAX_Y_NODES)) ? YNW'(MAX_Y_NODES) : YNW'(y_pts_r);

  // ------------------------------------------------------------ sequencer
  bgi_pkg::bgi_state_t state_r, state_nxt;

  logic        in_acc;
  logic        out_load;
  logic        idx_ok;

  // request capture
  logic        kind_r;
  logic [31:0] z_r;
  logic [31:0] mag_x_r, mag_y_r;
  logic        neg_x_r, neg_y_r;
  logic signed [32:0] dx, dy;

  assign dx = {in_ch.x_coord[31], in_ch.x_coord} - {x_origin_r[31], x_origin_r};
  assign dy = {in_ch.y_coord[31], in_ch.y_coord} - {y_origin_r[31], y_origin_r};

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  bgi_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // grid positions
  logic [63:0] px_r, py_r;

  // axis decode
  logic              ax_add_ok, ay_add_ok, ax_ev_ok, ay_ev_ok;
  logic [XIW-1:0]    ax_add_idx, ax_ev_lo;
  logic [YIW-1:0]    ay_add_idx, ay_ev_lo;
  logic [FRAC_BITS:0] ax_f, ay_f;

  bgi_axis #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (XIW),
    .NW        (XNW)
  ) u_axis_x (
    .pos     (px_r),
    .neg     (neg_x_r),
    .npts    (nx_eff),
    .add_ok  (ax_add_ok),
    .add_idx (ax_add_idx),
    .ev_ok   (ax_ev_ok),
    .ev_lo   (ax_ev_lo),
    .ev_f    (ax_f)
  );

  bgi_axis #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (YIW),
    .NW        (YNW)
  ) u_axis_y (
    .pos     (py_r),
    .neg     (neg_y_r),
    .npts    (ny_eff),
    .add_ok  (ay_add_ok),
    .add_idx (ay_add_idx),
    .ev_ok   (ay_ev_ok),
    .ev_lo   (ay_ev_lo),
    .ev_f    (ay_f)
  );

  assign idx_ok = (kind_r == bgi_pkg::KIND_EVAL) ? (ax_ev_ok & ay_ev_ok)
                                                 : (ax_add_ok & ay_add_ok);

  // cell corner and weights
  logic [XIW-1:0]     ix_r;
  logic [YIW-1:0]     iy_r;
  logic [FRAC_BITS:0] fx_r, fy_r;
  logic [FRAC_BITS:0] wx0, wy0;

  assign wx0 = ONE_F - fx_r;
  assign wy0 = ONE_F - fy_r;

  // node table
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [31:0]    mem_rdata;
  logic           mem_busy;
  logic [XIW-1:0] ix_sel;
  logic [YIW-1:0] iy_sel;

  assign mem_addr = AW'(ix_sel) * ROW_STRIDE + AW'(iy_sel);

  bgi_node_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (z_r),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  // corner values and blend pipeline
  logic [31:0]        n00_r, n10_r, n01_r, n11_r;
  logic [31:0]        z1_r, z2_r;
  logic signed [65:0] acc_r;
  logic signed [65:0] sum_w;
  logic [31:0]        rnd_w;

  // round half up to FRAC_BITS; the sum sits between its inputs, no clamp
  assign sum_w = acc_r + mul_p + RND_C;
  assign rnd_w = 32'(sum_w >>> FRAC_BITS);

  // result staging
  logic [31:0] res_r;
  logic        st_r;

  assign in_ch.ready = (state_r == bgi_pkg::S_IDLE) && !mem_busy;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == bgi_pkg::S_DONE) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bgi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    ix_sel    = ix_r;
    iy_sel    = iy_r;
    unique case (state_r)
      bgi_pkg::S_IDLE:  if (in_acc) state_nxt = bgi_pkg::S_MULX;
      bgi_pkg::S_MULX: begin
        mul_a     = {1'b0, mag_x_r};
        mul_b     = {1'b0, x_inv_r};
        state_nxt = bgi_pkg::S_MULY;
      end
      bgi_pkg::S_MULY: begin
        mul_a     = {1'b0, mag_y_r};
        mul_b     = {1'b0, y_inv_r};
        state_nxt = bgi_pkg::S_WAITY;
      end
      bgi_pkg::S_WAITY: state_nxt = bgi_pkg::S_INDEX;
      bgi_pkg::S_INDEX: begin
        priority if (!idx_ok)                        state_nxt = bgi_pkg::S_DONE;
        else if (kind_r == bgi_pkg::KIND_EVAL)       state_nxt = bgi_pkg::S_RD0;
        else                                         state_nxt = bgi_pkg::S_WRITE;
      end
      bgi_pkg::S_WRITE: begin
        mem_we    = 1'b1;
        state_nxt = bgi_pkg::S_DONE;
      end
      bgi_pkg::S_RD0: state_nxt = bgi_pkg::S_RD1;
      bgi_pkg::S_RD1: begin
        ix_sel    = ix_r + XIW'(1);
        state_nxt = bgi_pkg::S_RD2;
      end
      bgi_pkg::S_RD2: begin
        iy_sel    = iy_r + YIW'(1);
        state_nxt = bgi_pkg::S_RD3;
      end
      bgi_pkg::S_RD3: begin
        ix_sel    = ix_r + XIW'(1);
        iy_sel    = iy_r + YIW'(1);
        state_nxt = bgi_pkg::S_M0;
      end
      bgi_pkg::S_M0: begin
        mul_a     = {n00_r[31], n00_r};
        mul_b     = $signed(33'(wx0));
        state_nxt = bgi_pkg::S_M1;
      end
      bgi_pkg::S_M1: begin
        mul_a     = {n10_r[31], n10_r};
        mul_b     = $signed(33'(fx_r));
        state_nxt = bgi_pkg::S_M2;
      end
      bgi_pkg::S_M2: begin
        mul_a     = {n01_r[31], n01_r};
        mul_b     = $signed(33'(wx0));
        state_nxt = bgi_pkg::S_M3;
      end
      bgi_pkg::S_M3: begin
        mul_a     = {n11_r[31], n11_r};
        mul_b     = $signed(33'(fx_r));
        state_nxt = bgi_pkg::S_M4;
      end
      bgi_pkg::S_M4: begin
        mul_a     = {z1_r[31], z1_r};
        mul_b     = $signed(33'(wy0));
        state_nxt = bgi_pkg::S_M5;
      end
      bgi_pkg::S_M5: begin
        mul_a     = {z2_r[31], z2_r};
        mul_b     = $signed(33'(fy_r));
        state_nxt = bgi_pkg::S_M6;
      end
      bgi_pkg::S_M6: state_nxt = bgi_pkg::S_DONE;
      bgi_pkg::S_DONE: if (out_load) state_nxt = bgi_pkg::S_IDLE;
      default: state_nxt = bgi_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_ch.kind;
      z_r     <= in_ch.z_value;
      neg_x_r <= dx[32];
      neg_y_r <= dy[32];
      mag_x_r <= 32'(dx[32] ? -dx : dx);
      mag_y_r <= 32'(dy[32] ? -dy : dy);
      res_r   <= '0;
      st_r    <= bgi_pkg::STAT_OOR;
    end
    // product of MULX lands in MULY, product of MULY in WAITY
    if (state_r == bgi_pkg::S_MULY)  px_r <= mul_p[63:0];
    if (state_r == bgi_pkg::S_WAITY) py_r <= mul_p[63:0];
    if (state_r == bgi_pkg::S_INDEX) begin
      if (kind_r == bgi_pkg::KIND_EVAL) begin
        ix_r <= ax_ev_lo;
        iy_r <= ay_ev_lo;
      end else begin
        ix_r <= ax_add_idx;
        iy_r <= ay_add_idx;
      end
      fx_r <= ax_f;
      fy_r <= ay_f;
    end
    if (state_r == bgi_pkg::S_WRITE) st_r <= bgi_pkg::STAT_OK;
    // read data is registered and lands in the state after its address
    if (state_r == bgi_pkg::S_RD1) n00_r <= mem_rdata;
    if (state_r == bgi_pkg::S_RD2) n10_r <= mem_rdata;
    if (state_r == bgi_pkg::S_RD3) n01_r <= mem_rdata;
    if (state_r == bgi_pkg::S_M0)  n11_r <= mem_rdata;
    if (state_r == bgi_pkg::S_M1 || state_r == bgi_pkg::S_M3 ||
        state_r == bgi_pkg::S_M5) begin
      acc_r <= mul_p;
    end
    if (state_r == bgi_pkg::S_M2) z1_r <= rnd_w;
    if (state_r == bgi_pkg::S_M4) z2_r <= rnd_w;
    if (state_r == bgi_pkg::S_M6) begin
      res_r <= rnd_w;
      st_r  <= bgi_pkg::STAT_OK;
    end
  end

  // ---------------------------------------------------------- output reg
  logic        out_val_r;
  logic [31:0] out_res_r;
  logic        out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_val_r <= 1'b0;
    end else if (out_load) begin
      out_val_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_val_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_r;
      out_st_r  <= st_r;
    end
  end

  assign out_ch.valid        = out_val_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.status       = out_st_r;

  // ---------------------------------------------------------- assertions
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == bgi_pkg::S_MULX)
    else $error("accepted request did not start the position multiply");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_val_r && out_st_r == bgi_pkg::STAT_OOR) |-> out_res_r == '0)
    else $error("out-of-range result carries a nonzero value");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bgi_pkg::S_DONE && state_nxt == bgi_pkg::S_IDLE) |=> out_val_r)
    else $error("finished request left no result");

  a_no_req_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> state_r == bgi_pkg::S_IDLE && !mem_we)
    else $error("request in flight during table clear");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the uniform-grid bilinear interpolator.
// ----------------------------------------------------------------------------
// A scoreboard of expected results is filled by a local predictor of the grid
// table and its interpolation as each request is accepted. A separate process
// drains the result channel with random stalls and checks every result in
// order. Directed corner cases and special configurations come first, then many
// random grid setups with mostly on-grid positions, then a backpressure pass.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int FRAC  = 16;

  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_HALF = 32'h0000_8000;

  // indexes past the register list; writes there must be dropped
  localparam logic [bgi_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [bgi_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off

  typedef struct packed {
    logic signed [31:0] value;
    logic               status;
  } grid_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bgi_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bgi_pkg::DATA_W-1:0]    cfg_wdata;

  bgi_in_if  in_ch ();
  bgi_out_if out_ch ();

  uniform_grid_bilinear_interp_unit #(
    .MAX_X_NODES (MAX_X),
    .MAX_Y_NODES (MAX_Y),
    .FRAC_BITS   (FRAC)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block: register copies and the node table.
  // --------------------------------------------------------------------------
  logic signed [31:0] cfg_x_origin, cfg_y_origin;
  logic [31:0]        cfg_x_inv, cfg_y_inv;
  logic [6:0]         cfg_x_pts, cfg_y_pts;
  logic signed [31:0] node_mem [0:MAX_X*MAX_Y-1];

  grid_result_t pending_results [$];

  // run bookkeeping
  int fail_count;
  int n_requests, n_adds_stored, n_adds_offgrid, n_evals_inside, n_evals_offgrid;
  int n_cfg_writes, n_grid_setups;

  // idle control shared with the sender and the receiver
  bit tx_no_idle;
  bit rx_no_idle;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned eff_pts(input logic [6:0] v, input int unsigned maxn);
    if (v < 2) return 2;
    if (v > maxn) return maxn;
    return v;
  endfunction

  // |coord - origin| * inv in Q32.32; below is set when coord is under origin
  function automatic longint unsigned axis_pos(input logic signed [31:0] coord,
                                               input logic signed [31:0] origin,
                                               input logic [31:0] inv,
                                               output bit below);
    longint          d;
    longint unsigned mag;
    d     = longint'(coord) - longint'(origin);
    below = (d < 0);
    mag   = below ? $unsigned(-d) : $unsigned(d);
    return mag * {32'd0, inv};
  endfunction

  // nearest node, a half rounds up; up to half a step under origin is node 0
  function automatic bit add_node_index(input logic signed [31:0] coord,
                                        input logic signed [31:0] origin,
                                        input logic [31:0] inv,
                                        input int unsigned n,
                                        output int unsigned idx);
    longint unsigned p, i;
    bit              below;
    p   = axis_pos(coord, origin, inv, below);
    idx = 0;
    if (below) return (p <= (64'd1 << (2*FRAC-1)));
    i   = (p >> (2*FRAC)) + ((p >> (2*FRAC-1)) & 64'd1);
    idx = 32'(i);
    return (i < n);
  endfunction

  // enclosing cell and truncated fraction; exact top edge uses the last cell
  function automatic bit eval_cell(input logic signed [31:0] coord,
                                   input logic signed [31:0] origin,
                                   input logic [31:0] inv,
                                   input int unsigned n,
                                   output int unsigned lo,
                                   output longint f);
    longint unsigned p, ip, fr;
    bit              below;
    p  = axis_pos(coord, origin, inv, below);
    ip = p >> (2*FRAC);
    fr = p & 64'h0000_0000_FFFF_FFFF;
    lo = 0;
    f  = 0;
    if (below) return 1'b0;
    if (ip > n - 1 || (ip == n - 1 && fr != 0)) return 1'b0;
    if (ip == n - 1) begin
      lo = n - 2;
      f  = longint'(1) << FRAC;
    end else begin
      lo = 32'(ip);
      f  = longint'(fr >> FRAC);
    end
    return 1'b1;
  endfunction

  // a*(1-f) + b*f rounded half up to FRAC bits
  function automatic longint blend_round(input longint a, input longint b, input longint f);
    longint s;
    s = a * ((longint'(1) << FRAC) - f) + b * f;
    return (s + (longint'(1) << (FRAC-1))) >>> FRAC;
  endfunction

  function automatic longint node_at(input int unsigned ix, input int unsigned iy);
    return longint'(node_mem[ix*MAX_Y + iy]);
  endfunction

  function automatic grid_result_t interp_predict(input logic kind,
                                                  input logic signed [31:0] xc,
                                                  input logic signed [31:0] yc,
                                                  input logic signed [31:0] zv);
    grid_result_t r;
    int unsigned  nx, ny, ix, iy;
    longint       fx, fy, z1, z2, zb;
    r.value  = '0;
    r.status = bgi_pkg::STAT_OOR;
    nx = eff_pts(cfg_x_pts, MAX_X);
    ny = eff_pts(cfg_y_pts, MAX_Y);
    if (kind == bgi_pkg::KIND_ADD) begin
      if (add_node_index(xc, cfg_x_origin, cfg_x_inv, nx, ix) &&
          add_node_index(yc, cfg_y_origin, cfg_y_inv, ny, iy)) begin
        node_mem[ix*MAX_Y + iy] = zv;
        r.status = bgi_pkg::STAT_OK;
      end
    end else begin
      if (eval_cell(xc, cfg_x_origin, cfg_x_inv, nx, ix, fx) &&
          eval_cell(yc, cfg_y_origin, cfg_y_inv, ny, iy, fy)) begin
        // along x on both rows, then along y
        z1 = blend_round(node_at(ix, iy), node_at(ix + 1, iy), fx);
        z2 = blend_round(node_at(ix, iy + 1), node_at(ix + 1, iy + 1), fx);
        zb = blend_round(z1, z2, fy);
        r.value  = zb[31:0];
        r.status = bgi_pkg::STAT_OK;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Coordinate on one axis, mostly inside the grid: random positions, exact
  // nodes, the top edge and one past it, half-node points for add rounding,
  // and a little under the origin.
  function automatic logic [31:0] pick_axis_coord(input logic signed [31:0] origin,
                                                  input logic [31:0] inv,
                                                  input int unsigned n);
    longint unsigned span, k;
    longint          d, c;
    if (inv == 0) return $urandom();
    span = ((longint'(n) - 1) << 32) / inv;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: d = longint'({$urandom(), $urandom()} % (span + 1));
      6: begin
        k = $urandom_range(0, n - 1);
        d = longint'((k << 32) / inv);
      end
      7: d = longint'(span) + longint'($urandom_range(0, 1));
      8: begin
        k = $urandom_range(0, n - 1);
        d = longint'(((2*k + 1) << 31) / inv) + longint'(int'($urandom_range(0, 2)) - 1);
      end
      default: d = -longint'($urandom_range(0, 32'(((64'd1 << 31) / inv) + 2)));
    endcase
    c = longint'(origin) + d;
    if (c > longint'(32'sh7FFF_FFFF)) c = longint'(32'sh7FFF_FFFF);
    if (c < -longint'(64'h8000_0000)) c = -longint'(64'h8000_0000);
    return c[31:0];
  endfunction

  function automatic logic [31:0] pick_z();
    case ($urandom_range(0, 19))
      0, 1:    return 32'h7FFF_FFFF;
      2, 3:    return 32'h8000_0000;
      4:       return 32'h0000_0000;
      5:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 9))
      0, 1, 2: return 32'h0;
      3, 4, 5: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      6:       return 32'h8000_0000;
      7:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_inv();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'd1 << $urandom_range(10, 22);
      5, 6:          return $urandom_range(32'h0000_1000, 32'h0010_0000);
      7:             return $urandom();
      8:             return 32'd1;
      default:       return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [6:0] pick_points();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 7'($urandom_range(2, 6));
      6:                return 7'd64;
      7:                return 7'($urandom_range(0, 127));
      8:                return 7'($urandom_range(0, 1));
      default:          return 7'd127;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Bus tasks
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [bgi_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    n_cfg_writes++;
    case (idx)
      bgi_pkg::CFG_X_ORIGIN:   cfg_x_origin = data;
      bgi_pkg::CFG_Y_ORIGIN:   cfg_y_origin = data;
      bgi_pkg::CFG_X_INV_STEP: cfg_x_inv    = data;
      bgi_pkg::CFG_Y_INV_STEP: cfg_y_inv    = data;
      bgi_pkg::CFG_X_POINTS:   cfg_x_pts    = data[6:0];
      bgi_pkg::CFG_Y_POINTS:   cfg_y_pts    = data[6:0];
      default: ;
    endcase
  endtask

  task automatic setup_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] ix, input logic [31:0] iy,
                            input logic [6:0] px, input logic [6:0] py);
    write_reg(bgi_pkg::CFG_X_ORIGIN, ox);
    write_reg(bgi_pkg::CFG_Y_ORIGIN, oy);
    write_reg(bgi_pkg::CFG_X_INV_STEP, ix);
    write_reg(bgi_pkg::CFG_Y_INV_STEP, iy);
    write_reg(bgi_pkg::CFG_X_POINTS, {25'd0, px});
    write_reg(bgi_pkg::CFG_Y_POINTS, {25'd0, py});
    n_grid_setups++;
  endtask

  // Offer one request after a random gap; the expectation is taken at the
  // edge where it is accepted.
  task automatic send_request(input logic kind, input logic [31:0] xc,
                              input logic [31:0] yc, input logic [31:0] zv);
    int unsigned  gap;
    grid_result_t exp_r;
    gap = tx_no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.kind    = kind;
    in_ch.x_coord = xc;
    in_ch.y_coord = yc;
    in_ch.z_value = zv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_r = interp_predict(kind, xc, yc, zv);
    pending_results.push_back(exp_r);
    n_requests++;
    if (kind == bgi_pkg::KIND_ADD) begin
      if (exp_r.status == bgi_pkg::STAT_OK) n_adds_stored++;
      else n_adds_offgrid++;
    end else begin
      if (exp_r.status == bgi_pkg::STAT_OK) n_evals_inside++;
      else n_evals_offgrid++;
    end
  endtask

  // sender goes quiet until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // one request, mostly on the current grid
  task automatic send_grid_request();
    int unsigned r, nx, ny;
    logic        kind;
    nx = eff_pts(cfg_x_pts, MAX_X);
    ny = eff_pts(cfg_y_pts, MAX_Y);
    r  = $urandom_range(0, 99);
    if (r < 85) begin
      kind = (r < 40) ? bgi_pkg::KIND_ADD : bgi_pkg::KIND_EVAL;
      send_request(kind, pick_axis_coord(cfg_x_origin, cfg_x_inv, nx),
                   pick_axis_coord(cfg_y_origin, cfg_y_inv, ny), pick_z());
    end else begin
      // noise: raw words everywhere
      send_request(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset grid: 2x2 nodes at unit spacing from the origin.
  task automatic test_directed_corners();
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    // cleared table reads back zero
    send_request(bgi_pkg::KIND_EVAL, 32'h0, 32'h0, 32'h0);
    // load the corners with extreme values
    send_request(bgi_pkg::KIND_ADD, 32'h0, 32'h0, 32'h7FFF_FFFF);
    send_request(bgi_pkg::KIND_ADD, Q_ONE, 32'h0, 32'h8000_0000);
    // x at one half rounds up to node 1
    send_request(bgi_pkg::KIND_ADD, Q_HALF, Q_ONE, 32'hFFFF_FFFF);
    // half a step under origin lands on node 0; y just below 1.5 rounds to 1
    send_request(bgi_pkg::KIND_ADD, -Q_HALF, Q_ONE + Q_HALF - 1, 32'h0001_2345);
    // one lsb more than half under origin is off grid
    send_request(bgi_pkg::KIND_ADD, -Q_HALF - 1, 32'h0, 32'h1111_1111);
    // 1.5 rounds to index 2, past the last node
    send_request(bgi_pkg::KIND_ADD, Q_ONE + Q_HALF, 32'h0, 32'h2222_2222);
    send_request(bgi_pkg::KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h3333_3333);
    // cell center, exact top edge on both axes, one lsb beyond it
    send_request(bgi_pkg::KIND_EVAL, Q_HALF, Q_HALF, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, Q_ONE, Q_ONE, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, Q_ONE + 1, 32'h0, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, Q_ONE, 32'h0000_4000, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, 32'h0000_0001, 32'h0000_FFFF, 32'h0);
    // z is a don't-care on evaluate
    send_request(bgi_pkg::KIND_EVAL, Q_HALF, 32'h0, 32'h7FFF_FFFF);
    drain_results();
  endtask

  // Zero step, clamped point counts, dropped register index, extreme origins.
  task automatic test_special_configs();
    // zero reciprocal step: every position collapses to node 0
    write_reg(bgi_pkg::CFG_X_INV_STEP, 32'h0);
    write_reg(bgi_pkg::CFG_Y_INV_STEP, 32'h0);
    send_request(bgi_pkg::KIND_ADD, $urandom(), $urandom(), 32'h5A5A_A5A5);
    send_request(bgi_pkg::KIND_EVAL, $urandom(), $urandom(), 32'h0);
    drain_results();
    // counts below 2 and above the maximum are clamped
    write_reg(bgi_pkg::CFG_X_INV_STEP, Q_ONE);
    write_reg(bgi_pkg::CFG_Y_INV_STEP, Q_ONE);
    write_reg(bgi_pkg::CFG_X_POINTS, 32'd0);
    write_reg(bgi_pkg::CFG_Y_POINTS, 32'd127);
    send_request(bgi_pkg::KIND_ADD, 32'h0, 32'h003F_0000, 32'hDEAD_BEEF);
    send_request(bgi_pkg::KIND_EVAL, Q_ONE, 32'h003F_0000, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, Q_ONE + 1, 32'h003F_0000, 32'h0);
    drain_results();
    // writes past the register list must not land anywhere
    write_reg(bgi_pkg::CFG_X_POINTS, 32'd1);
    write_reg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_HI, 32'h0000_0040);
    send_request(bgi_pkg::KIND_EVAL, Q_ONE, Q_HALF, 32'h0);
    drain_results();
    // extreme origins with the smallest and largest steps
    setup_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF, 7'd2, 7'd64);
    send_request(bgi_pkg::KIND_EVAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_request(bgi_pkg::KIND_EVAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_request(bgi_pkg::KIND_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001);
    drain_results();
  endtask

  // Random grid setups, each followed by a batch of mostly on-grid requests.
  task automatic test_random_grids(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      case (ph)
        0: setup_grid(32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1, 7'd64, 7'd2);
        1: setup_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd2, 7'd64);
        2: setup_grid(32'h0, 32'h0, Q_ONE, Q_ONE, 7'd64, 7'd64);
        default: setup_grid(pick_origin(), pick_origin(), pick_inv(), pick_inv(),
                            pick_points(), pick_points());
      endcase
      // some batches run back to back on one or both sides
      tx_no_idle = ($urandom_range(0, 3) == 0);
      rx_no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < per_phase; i++) send_grid_request();
      drain_results();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so
  // the output register and the unit fill and the input stalls. Then the
  // sender pauses mid-stream until every result is back.
  task automatic test_backpressure();
    setup_grid(32'h0, 32'h0, Q_ONE, Q_ONE, 7'd3, 7'd3);
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    hold_req   = 1'b1;
    for (int i = 0; i < 30; i++) send_grid_request();
    for (int i = 0; i < 15; i++) send_grid_request();
    drain_results();
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
    for (int i = 0; i < 15; i++) send_grid_request();
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Result checker: random stalls per result, long hold on request.
  // --------------------------------------------------------------------------
  initial begin : result_checker
    int unsigned  stall_left;
    int unsigned  hold_left;
    grid_result_t exp_r;
    stall_left   = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: result_value %h status %b",
                 out_ch.result_value, out_ch.status);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.result_value !== exp_r.value) begin
            $error("result_value mismatch: expected %h, got %h",
                   exp_r.value, out_ch.result_value);
            fail_count++;
          end
          if (out_ch.status !== exp_r.status) begin
            $error("status mismatch: expected %b, got %b", exp_r.status, out_ch.status);
            fail_count++;
          end
        end
        stall_left = rx_no_idle ? 0 : $urandom_range(0, 11);
      end
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    fail_count      = 0;
    n_requests      = 0;
    n_adds_stored   = 0;
    n_adds_offgrid  = 0;
    n_evals_inside  = 0;
    n_evals_offgrid = 0;
    n_cfg_writes    = 0;
    n_grid_setups   = 0;
    tx_no_idle      = 1'b0;
    rx_no_idle      = 1'b0;
    hold_req        = 1'b0;

    in_ch.valid   = 1'b0;
    in_ch.kind    = bgi_pkg::KIND_ADD;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.z_value = '0;
    cfg_we        = 1'b0;
    cfg_index     = bgi_pkg::CFG_X_ORIGIN;
    cfg_wdata     = '0;

    // reset values of the shadow: cleared table, unit grid of 2x2
    cfg_x_origin = '0;
    cfg_y_origin = '0;
    cfg_x_inv    = 32'd65536;
    cfg_y_inv    = 32'd65536;
    cfg_x_pts    = bgi_pkg::MIN_POINTS;
    cfg_y_pts    = bgi_pkg::MIN_POINTS;
    foreach (node_mem[i]) node_mem[i] = '0;

    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // the table sweep after reset just shows up as a long first stall

    test_directed_corners();
    test_special_configs();
    test_random_grids(16, 100);
    test_backpressure();

    drain_results();
    // room for anything stray to come out
    repeat (40) @(posedge clk);

    $display("summary: %0d requests: %0d adds stored, %0d adds off grid,",
             n_requests, n_adds_stored, n_adds_offgrid);
    $display("summary: %0d evaluates inside, %0d evaluates off grid, %0d register writes",
             n_evals_inside, n_evals_offgrid, n_cfg_writes);
    $display("summary: %0d grid setups, %0d check failures", n_grid_setups, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : run_limit
    #(5_000_000);
    $display("timeout: %0d results still outstanding", pending_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
